// File: src/pointer_to_stick_deadzone_shaper_defines.svh
// assertion helpers for the stick shaper, clocked on clk, held off during reset
`ifndef POINTER_TO_STICK_DEADZONE_SHAPER_DEFINES_SVH
`define POINTER_TO_STICK_DEADZONE_SHAPER_DEFINES_SVH

// same-cycle implication
`define PTSDS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stick shaper check failed");

// next-cycle implication
`define PTSDS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stick shaper check failed");

`endif

// File: src/ptsds_pkg.sv
package ptsds_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 15;
  // fractional bits of the radial distance
  localparam int DIST_FRAC      = 14;
  // entries in the queue between front and back
  localparam int QUEUE_DEPTH    = 4;

  localparam int CFG_INDEX_W    = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_WINDOW_WIDTH  = 3'd0,
    CFG_WINDOW_HEIGHT = 3'd1,
    CFG_CENTER_X      = 3'd2,
    CFG_CENTER_Y      = 3'd3,
    CFG_DEAD_ZONE     = 3'd4,
    CFG_LINEAR        = 3'd5
  } cfg_reg_t;

  localparam int RST_WINDOW_WIDTH  = 1024;
  localparam int RST_WINDOW_HEIGHT = 768;
  localparam int RST_CENTER_X      = 512;
  localparam int RST_CENTER_Y      = 384;
  localparam int RST_DEAD_ZONE     = 20;

endpackage

// File: src/ptsds_front.sv
module ptsds_front #(
  parameter int COORD_BITS = ptsds_pkg::COORD_BITS_DEF,
  parameter int DEPTH      = ptsds_pkg::QUEUE_DEPTH,
  parameter int ITEM_W     = 2 * COORD_BITS + 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] in_pointer_x,
  input  logic [COORD_BITS-1:0] in_pointer_y,
  input  logic                  in_pointer_valid,
  input  logic [COORD_BITS-1:0] window_width,
  input  logic [COORD_BITS-1:0] window_height,
  input  logic [COORD_BITS-1:0] center_x,
  input  logic [COORD_BITS-1:0] center_y,
  input  logic                  pop,
  output logic                  head_valid,
  output logic [ITEM_W-1:0]     head_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef struct packed {
    logic                  upd;
    logic                  negx;
    logic [COORD_BITS-1:0] offx;
    logic                  negy;
    logic [COORD_BITS-1:0] offy;
  } item_t;

  item_t           item_new;
  item_t           mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            push;

  // classify: window check, offsets from centre, sign of each offset
  always_comb begin
    item_new.upd  = in_pointer_valid && (in_pointer_x < window_width) &&
                    (in_pointer_y < window_height);
    item_new.negx = in_pointer_x < center_x;
    item_new.offx = item_new.negx ? center_x - in_pointer_x : in_pointer_x - center_x;
    item_new.negy = in_pointer_y < center_y;
    item_new.offy = item_new.negy ? center_y - in_pointer_y : in_pointer_y - center_y;
  end

  assign in_ready   = cnt_r != CW'(DEPTH);
  assign push       = in_valid && in_ready;
  assign head_valid = cnt_r != '0;
  assign head_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_new;
    end
  end

endmodule

// File: src/ptsds_sqrt.sv
module ptsds_sqrt #(
  parameter int ROOT_W = 27,
  parameter int SIDE_W = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  logic [2*ROOT_W-1:0]   in_val,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_vld,
  output logic [ROOT_W-1:0]     out_root,
  output logic [SIDE_W-1:0]     out_side
);

  localparam int VW = 2 * ROOT_W;
  localparam int RW = ROOT_W + 2;

  // one root bit per stage
  logic [ROOT_W-1:0] vld_r, vld_nxt;
  logic [RW-1:0]     rem_r  [ROOT_W];
  logic [RW-1:0]     rem_nxt[ROOT_W];
  logic [ROOT_W-1:0] root_r  [ROOT_W];
  logic [ROOT_W-1:0] root_nxt[ROOT_W];
  logic [VW-1:0]     val_r  [ROOT_W];
  logic [VW-1:0]     val_nxt[ROOT_W];
  logic [SIDE_W-1:0] side_r  [ROOT_W];
  logic [SIDE_W-1:0] side_nxt[ROOT_W];

  always_comb begin
    logic [RW-1:0]     rem_i;
    logic [ROOT_W-1:0] root_i;
    logic [VW-1:0]     val_i;
    logic [RW-1:0]     rem_s;
    logic [RW-1:0]     trial;
    for (int k = 0; k < ROOT_W; k++) begin
      if (k == 0) begin
        rem_i       = '0;
        root_i      = '0;
        val_i       = in_val;
        vld_nxt[k]  = in_vld;
        side_nxt[k] = in_side;
      end else begin
        rem_i       = rem_r[k-1];
        root_i      = root_r[k-1];
        val_i       = val_r[k-1];
        vld_nxt[k]  = vld_r[k-1];
        side_nxt[k] = side_r[k-1];
      end
      rem_s = {rem_i[RW-3:0], val_i[VW-1 -: 2]};
      trial = {root_i, 2'b01};
      if (rem_s >= trial) begin
        rem_nxt[k]  = rem_s - trial;
        root_nxt[k] = {root_i[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = rem_s;
        root_nxt[k] = {root_i[ROOT_W-2:0], 1'b0};
      end
      val_nxt[k] = {val_i[VW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < ROOT_W; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        val_r[k]  <= val_nxt[k];
        side_r[k] <= side_nxt[k];
      end
    end
  end

  assign out_vld  = vld_r[ROOT_W-1];
  assign out_root = root_r[ROOT_W-1];
  assign out_side = side_r[ROOT_W-1];

endmodule

// File: src/ptsds_axis.sv
module ptsds_axis #(
  parameter int COORD_BITS = ptsds_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = ptsds_pkg::FRAC_BITS_DEF,
  parameter int DIST_W     = COORD_BITS + 1 + ptsds_pkg::DIST_FRAC
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  logic [DIST_W-1:0]     in_dist,
  input  logic [COORD_BITS-1:0] in_off,
  input  logic                  in_neg,
  input  logic                  in_live,
  input  logic                  in_upd,
  input  logic [COORD_BITS-1:0] radius,
  input  logic [COORD_BITS-1:0] centre,
  input  logic                  linear,
  output logic                  out_vld,
  output logic                  out_upd,
  output logic [FRAC_BITS:0]    out_val
);

  localparam int DF = ptsds_pkg::DIST_FRAC;
  localparam int NW = COORD_BITS + DIST_W;
  localparam int MW = FRAC_BITS + 1;

  typedef struct packed {
    logic zero;
    logic full;
    logic neg;
    logic live;
    logic upd;
  } tag_t;

  // scale numerator and denominator
  logic [DIST_W-1:0] rad_q, dist_c, diff;
  logic [NW-1:0]     num, den;
  logic              a0_vld_r;
  logic [NW-1:0]     a0_num_r, a0_den_r;
  tag_t              a0_tag_r, a0_tag;

  always_comb begin
    rad_q  = {{(DIST_W-COORD_BITS-DF){1'b0}}, radius, {DF{1'b0}}};
    dist_c = (in_dist < rad_q) ? rad_q : in_dist;
    diff   = dist_c - rad_q;
    num    = {{DIST_W{1'b0}}, in_off} * {{COORD_BITS{1'b0}}, diff};
    den    = {{DIST_W{1'b0}}, centre} * {{COORD_BITS{1'b0}}, dist_c};
    a0_tag      = '0;
    a0_tag.neg  = in_neg;
    a0_tag.live = in_live;
    a0_tag.upd  = in_upd;
  end

  // divide setup: zero and full-scale short cuts
  logic          a1_vld_r;
  logic [NW-1:0] a1_rem_r, a1_den_r;
  tag_t          a1_tag_r, a1_tag;

  always_comb begin
    a1_tag      = a0_tag_r;
    a1_tag.zero = a0_num_r == '0;
    a1_tag.full = (a0_den_r == '0) || (a0_num_r >= a0_den_r);
  end

  // restoring division, one quotient bit per stage
  logic [FRAC_BITS-1:0] dv_vld_r, dv_vld_nxt;
  logic [NW-1:0]        dv_rem_r  [FRAC_BITS];
  logic [NW-1:0]        dv_rem_nxt[FRAC_BITS];
  logic [NW-1:0]        dv_den_r  [FRAC_BITS];
  logic [NW-1:0]        dv_den_nxt[FRAC_BITS];
  logic [FRAC_BITS-1:0] dv_q_r  [FRAC_BITS];
  logic [FRAC_BITS-1:0] dv_q_nxt[FRAC_BITS];
  tag_t                 dv_tag_r  [FRAC_BITS];
  tag_t                 dv_tag_nxt[FRAC_BITS];

  always_comb begin
    logic [NW-1:0]        rem_i;
    logic [NW-1:0]        den_i;
    logic [FRAC_BITS-1:0] q_i;
    logic [NW:0]          rem_s;
    for (int k = 0; k < FRAC_BITS; k++) begin
      if (k == 0) begin
        rem_i         = a1_rem_r;
        den_i         = a1_den_r;
        q_i           = '0;
        dv_vld_nxt[k] = a1_vld_r;
        dv_tag_nxt[k] = a1_tag_r;
      end else begin
        rem_i         = dv_rem_r[k-1];
        den_i         = dv_den_r[k-1];
        q_i           = dv_q_r[k-1];
        dv_vld_nxt[k] = dv_vld_r[k-1];
        dv_tag_nxt[k] = dv_tag_r[k-1];
      end
      rem_s         = {rem_i, 1'b0};
      dv_den_nxt[k] = den_i;
      if (rem_s >= {1'b0, den_i}) begin
        dv_rem_nxt[k] = NW'(rem_s - {1'b0, den_i});
        dv_q_nxt[k]   = {q_i[FRAC_BITS-2:0], 1'b1};
      end else begin
        dv_rem_nxt[k] = rem_s[NW-1:0];
        dv_q_nxt[k]   = {q_i[FRAC_BITS-2:0], 1'b0};
      end
    end
  end

  // response curve
  logic            a2_vld_r;
  logic [MW-1:0]   a2_m_r, m_lin, m_shaped;
  logic [2*MW-1:0] m_sq;
  tag_t            a2_tag_r, last_tag;

  always_comb begin
    last_tag = dv_tag_r[FRAC_BITS-1];
    if (last_tag.zero) begin
      m_lin = '0;
    end else if (last_tag.full) begin
      m_lin = {1'b1, {FRAC_BITS{1'b0}}};
    end else begin
      m_lin = {1'b0, dv_q_r[FRAC_BITS-1]};
    end
    m_sq     = {{MW{1'b0}}, m_lin} * {{MW{1'b0}}, m_lin};
    m_shaped = linear ? m_lin : m_sq[FRAC_BITS +: MW];
  end

  // saturate and apply sign
  logic          a3_vld_r, a3_upd_r;
  logic [MW-1:0] a3_val_r, m_sat, val;

  always_comb begin
    m_sat = a2_m_r;
    if (!a2_tag_r.neg && a2_m_r > {1'b0, {FRAC_BITS{1'b1}}}) begin
      m_sat = {1'b0, {FRAC_BITS{1'b1}}};
    end
    val = a2_tag_r.neg ? '0 - m_sat : m_sat;
    if (!a2_tag_r.live) begin
      val = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a0_vld_r <= 1'b0;
      a1_vld_r <= 1'b0;
      dv_vld_r <= '0;
      a2_vld_r <= 1'b0;
      a3_vld_r <= 1'b0;
    end else if (en) begin
      a0_vld_r <= in_vld;
      a1_vld_r <= a0_vld_r;
      dv_vld_r <= dv_vld_nxt;
      a2_vld_r <= dv_vld_r[FRAC_BITS-1];
      a3_vld_r <= a2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a0_num_r <= num;
      a0_den_r <= den;
      a0_tag_r <= a0_tag;
      a1_rem_r <= a0_num_r;
      a1_den_r <= a0_den_r;
      a1_tag_r <= a1_tag;
      for (int k = 0; k < FRAC_BITS; k++) begin
        dv_rem_r[k] <= dv_rem_nxt[k];
        dv_den_r[k] <= dv_den_nxt[k];
        dv_q_r[k]   <= dv_q_nxt[k];
        dv_tag_r[k] <= dv_tag_nxt[k];
      end
      a2_m_r   <= m_shaped;
      a2_tag_r <= last_tag;
      a3_val_r <= val;
      a3_upd_r <= a2_tag_r.upd;
    end
  end

  assign out_vld = a3_vld_r;
  assign out_upd = a3_upd_r;
  assign out_val = a3_val_r;

endmodule

// File: src/ptsds_back.sv
module ptsds_back #(
  parameter int COORD_BITS = ptsds_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = ptsds_pkg::FRAC_BITS_DEF,
  parameter int ITEM_W     = 2 * COORD_BITS + 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  head_valid,
  input  logic [ITEM_W-1:0]     head_item,
  output logic                  pop,
  input  logic [COORD_BITS-1:0] center_x,
  input  logic [COORD_BITS-1:0] center_y,
  input  logic [COORD_BITS-1:0] dead_zone_radius,
  input  logic                  linear_response,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_updated,
  output logic [FRAC_BITS:0]    out_aileron,
  output logic [FRAC_BITS:0]    out_elevator
);

  localparam int DF     = ptsds_pkg::DIST_FRAC;
  localparam int SQW    = 2 * COORD_BITS;
  localparam int D2W    = SQW + 1;
  localparam int ROOT_W = COORD_BITS + 1 + DF;
  localparam int VW     = 2 * ROOT_W;
  localparam int SIDE_W = ITEM_W + 1;

  typedef struct packed {
    logic                  upd;
    logic                  negx;
    logic [COORD_BITS-1:0] offx;
    logic                  negy;
    logic [COORD_BITS-1:0] offy;
  } item_t;

  typedef struct packed {
    logic  live;
    item_t item;
  } side_t;

  logic en;
  // whole pipeline moves unless a finished beat is stuck at the output
  assign en  = !out_valid || out_ready;
  assign pop = en && head_valid;

  item_t           head;
  logic            b0_vld_r;
  item_t           b0_item_r;
  logic [SQW-1:0]  b0_sqx_r, b0_sqy_r, b0_r2_r;

  assign head = item_t'(head_item);

  logic            b1_vld_r;
  side_t           b1_side_r, b1_side;
  logic [VW-1:0]   b1_v_r, b1_v;
  logic [D2W-1:0]  d2;

  always_comb begin
    d2           = {1'b0, b0_sqx_r} + {1'b0, b0_sqy_r};
    b1_side.item = b0_item_r;
    b1_side.live = b0_item_r.upd && (d2 > {1'b0, b0_r2_r});
    b1_v         = {{(VW-D2W-2*DF){1'b0}}, d2, {(2*DF){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_vld_r <= 1'b0;
      b1_vld_r <= 1'b0;
    end else if (en) begin
      b0_vld_r <= head_valid;
      b1_vld_r <= b0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b0_item_r <= head;
      b0_sqx_r  <= {{COORD_BITS{1'b0}}, head.offx} * {{COORD_BITS{1'b0}}, head.offx};
      b0_sqy_r  <= {{COORD_BITS{1'b0}}, head.offy} * {{COORD_BITS{1'b0}}, head.offy};
      b0_r2_r   <= {{COORD_BITS{1'b0}}, dead_zone_radius} *
                   {{COORD_BITS{1'b0}}, dead_zone_radius};
      b1_side_r <= b1_side;
      b1_v_r    <= b1_v;
    end
  end

  logic              rt_vld;
  logic [ROOT_W-1:0] rt_root;
  logic [SIDE_W-1:0] rt_side_bits;
  side_t             rt_side;

  ptsds_sqrt #(
    .ROOT_W (ROOT_W),
    .SIDE_W (SIDE_W)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (b1_vld_r),
    .in_val   (b1_v_r),
    .in_side  (b1_side_r),
    .out_vld  (rt_vld),
    .out_root (rt_root),
    .out_side (rt_side_bits)
  );

  assign rt_side = side_t'(rt_side_bits);

  logic               ax_vld, ax_upd;
  logic [FRAC_BITS:0] ax_val, el_val;

  ptsds_axis #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .DIST_W     (ROOT_W)
  ) u_axis_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (rt_vld),
    .in_dist (rt_root),
    .in_off  (rt_side.item.offx),
    .in_neg  (rt_side.item.negx),
    .in_live (rt_side.live),
    .in_upd  (rt_side.item.upd),
    .radius  (dead_zone_radius),
    .centre  (center_x),
    .linear  (linear_response),
    .out_vld (ax_vld),
    .out_upd (ax_upd),
    .out_val (ax_val)
  );

  ptsds_axis #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .DIST_W     (ROOT_W)
  ) u_axis_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (rt_vld),
    .in_dist (rt_root),
    .in_off  (rt_side.item.offy),
    .in_neg  (rt_side.item.negy),
    .in_live (rt_side.live),
    .in_upd  (rt_side.item.upd),
    .radius  (dead_zone_radius),
    .centre  (center_y),
    .linear  (linear_response),
    .out_vld (),
    .out_upd (),
    .out_val (el_val)
  );

  // output register
  logic               out_valid_r, out_updated_r;
  logic [FRAC_BITS:0] out_aileron_r, out_elevator_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ax_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_updated_r  <= ax_upd;
      out_aileron_r  <= ax_val;
      out_elevator_r <= el_val;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_updated  = out_updated_r;
  assign out_aileron  = out_aileron_r;
  assign out_elevator = out_elevator_r;

endmodule

// File: src/pointer_to_stick_deadzone_shaper.sv
// Pointer-to-stick shaper: each pointer beat (column, row, valid flag) gives one result beat
// with aileron and elevator in Q1.FRAC_BITS and an updated flag; a beat that is invalid or
// outside the window comes out with updated low and both sticks zero. Inside the radial dead
// zone (edge included) both sticks are zero; outside it each stick is offset / centre scaled
// by (d - r) / d, then squared with sign kept unless linear_response is set, and saturated.
// Throughput is one beat per clock, limited by nothing but output backpressure: a four-entry
// queue takes samples while the back pipeline stalls. From acceptance a beat passes the
// queue, the squaring stages, the square-root pipeline (one root bit per stage), the per-axis
// divider (one quotient bit per stage), the response curve and the output register.
// Configuration registers are written through cfg_we / cfg_index / cfg_wdata and must only
// change while no beat is in flight; unknown indices are ignored.
`include "pointer_to_stick_deadzone_shaper_defines.svh"

module pointer_to_stick_deadzone_shaper #(
  parameter int COORD_BITS = ptsds_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = ptsds_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // config write port
  input  logic                              cfg_we,
  input  logic [ptsds_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]             cfg_wdata,
  // pointer beats
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [COORD_BITS-1:0]             in_pointer_x,
  input  logic [COORD_BITS-1:0]             in_pointer_y,
  input  logic                              in_pointer_valid,
  // stick beats
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_updated,
  output logic signed [FRAC_BITS:0]         out_aileron,
  output logic signed [FRAC_BITS:0]         out_elevator
);

  localparam int ITEM_W = 2 * COORD_BITS + 3;

  // configuration registers
  logic [COORD_BITS-1:0] window_width_r, window_height_r;
  logic [COORD_BITS-1:0] center_x_r, center_y_r, dead_zone_r;
  logic                  linear_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_width_r  <= COORD_BITS'(ptsds_pkg::RST_WINDOW_WIDTH);
      window_height_r <= COORD_BITS'(ptsds_pkg::RST_WINDOW_HEIGHT);
      center_x_r      <= COORD_BITS'(ptsds_pkg::RST_CENTER_X);
      center_y_r      <= COORD_BITS'(ptsds_pkg::RST_CENTER_Y);
      dead_zone_r     <= COORD_BITS'(ptsds_pkg::RST_DEAD_ZONE);
      linear_r        <= 1'b0;
    end else if (cfg_we) begin
      case (ptsds_pkg::cfg_reg_t'(cfg_index))
        ptsds_pkg::CFG_WINDOW_WIDTH:  window_width_r  <= cfg_wdata;
        ptsds_pkg::CFG_WINDOW_HEIGHT: window_height_r <= cfg_wdata;
        ptsds_pkg::CFG_CENTER_X:      center_x_r      <= cfg_wdata;
        ptsds_pkg::CFG_CENTER_Y:      center_y_r      <= cfg_wdata;
        ptsds_pkg::CFG_DEAD_ZONE:     dead_zone_r     <= cfg_wdata;
        ptsds_pkg::CFG_LINEAR:        linear_r        <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // front: classify and queue
  logic              head_valid, pop;
  logic [ITEM_W-1:0] head_item;

  ptsds_front #(
    .COORD_BITS (COORD_BITS),
    .DEPTH      (ptsds_pkg::QUEUE_DEPTH),
    .ITEM_W     (ITEM_W)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pointer_x     (in_pointer_x),
    .in_pointer_y     (in_pointer_y),
    .in_pointer_valid (in_pointer_valid),
    .window_width     (window_width_r),
    .window_height    (window_height_r),
    .center_x         (center_x_r),
    .center_y         (center_y_r),
    .pop              (pop),
    .head_valid       (head_valid),
    .head_item        (head_item)
  );

  // back: distance, scaling, curve, output register
  logic [FRAC_BITS:0] aileron, elevator;

  ptsds_back #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .ITEM_W     (ITEM_W)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (head_valid),
    .head_item        (head_item),
    .pop              (pop),
    .center_x         (center_x_r),
    .center_y         (center_y_r),
    .dead_zone_radius (dead_zone_r),
    .linear_response  (linear_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_updated      (out_updated),
    .out_aileron      (aileron),
    .out_elevator     (elevator)
  );

  assign out_aileron  = aileron;
  assign out_elevator = elevator;

  // a beat that was not updated carries zero sticks
  `PTSDS_ASSERT_NOW(a_not_updated_zero, out_valid && !out_updated,
                    out_aileron == '0 && out_elevator == '0)
  // an empty queue always has room
  `PTSDS_ASSERT_NOW(a_empty_has_room, !head_valid, in_ready)
  // an accepted beat is in the queue on the next cycle
  `PTSDS_ASSERT_NEXT(a_push_fills, in_valid && in_ready, head_valid)

endmodule

// File: verif/tb_pointer_to_stick_deadzone_shaper.sv
module tb_pointer_to_stick_deadzone_shaper;

  localparam int CW = 12;
  localparam int FB = 15;
  localparam int IW = ptsds_pkg::CFG_INDEX_W;
  // wait after the last expected result before the next phase
  localparam int DRAIN_CYCLES = 80;
  // indexes past the last register, writes there must do nothing
  localparam logic [IW-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [IW-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic              updated;
    logic signed [FB:0] aileron;
    logic signed [FB:0] elevator;
  } stick_t;

  typedef struct {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic          v;
    bit            typed;   // expectation written out by hand
    stick_t        want;
  } sample_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [IW-1:0] cfg_index = '0;
  logic [CW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CW-1:0] in_pointer_x = '0;
  logic [CW-1:0] in_pointer_y = '0;
  logic in_pointer_valid = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_updated;
  logic signed [FB:0] out_aileron;
  logic signed [FB:0] out_elevator;

  pointer_to_stick_deadzone_shaper uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_pointer_x(in_pointer_x), .in_pointer_y(in_pointer_y),
    .in_pointer_valid(in_pointer_valid),
    .out_valid(out_valid), .out_ready(out_ready), .out_updated(out_updated),
    .out_aileron(out_aileron), .out_elevator(out_elevator)
  );

  always #1 clk = ~clk;

  // shadow of the register file
  logic [CW-1:0] win_w, win_h, cen_x, cen_y, dz_rad;
  logic          lin_mode;

  stick_t pending_sticks[$];
  int     fail_cnt = 0;
  bit     calm = 0;        // no idling on either side
  bit     hold_req = 0;    // ask the receiver for a long hold-off

  // integer square root, one result bit per pass
  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // one stick: offset / centre * (d - r) / d, optional signed square, saturate
  function automatic logic [FB:0] axis_stick(longint unsigned pos, longint unsigned cen,
                                             longint unsigned dist_q, longint unsigned rad);
    longint unsigned full = 64'd1 << FB;
    longint unsigned off, num, den, q, rem;
    bit neg;
    neg = pos < cen;
    off = neg ? cen - pos : pos - cen;
    num = off * (dist_q - rad);
    den = cen * dist_q;
    if (num == 0) q = 0;
    else if (den == 0 || num >= den) q = full;
    else begin
      q = 0;
      rem = num;
      for (int i = 0; i < FB; i++) begin
        rem <<= 1;
        q <<= 1;
        if (rem >= den) begin
          rem -= den;
          q |= 1;
        end
      end
    end
    if (!lin_mode) q = (q * q) >> FB;
    if (!neg && q > full - 1) q = full - 1;
    return neg ? (FB+1)'(-q) : (FB+1)'(q);
  endfunction

  function automatic stick_t predict_sticks(logic [CW-1:0] x, logic [CW-1:0] y, logic v);
    stick_t s;
    longint unsigned dx, dy, d2, dist_q, rad;
    s = '0;
    if (!v || x >= win_w || y >= win_h) return s;
    s.updated = 1'b1;
    dx = (x >= cen_x) ? x - cen_x : cen_x - x;
    dy = (y >= cen_y) ? y - cen_y : cen_y - y;
    d2 = dx * dx + dy * dy;
    if (d2 > longint'(dz_rad) * dz_rad) begin
      dist_q = int_root(d2 << (2 * ptsds_pkg::DIST_FRAC));
      rad = longint'(dz_rad) << ptsds_pkg::DIST_FRAC;
      if (dist_q < rad) dist_q = rad;
      s.aileron = axis_stick(x, cen_x, dist_q, rad);
      s.elevator = axis_stick(y, cen_y, dist_q, rad);
    end
    return s;
  endfunction

  // register write, called at a falling edge with the block idle
  task automatic write_reg(logic [IW-1:0] idx, logic [CW-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      ptsds_pkg::CFG_WINDOW_WIDTH:  win_w = val;
      ptsds_pkg::CFG_WINDOW_HEIGHT: win_h = val;
      ptsds_pkg::CFG_CENTER_X:      cen_x = val;
      ptsds_pkg::CFG_CENTER_Y:      cen_y = val;
      ptsds_pkg::CFG_DEAD_ZONE:     dz_rad = val;
      ptsds_pkg::CFG_LINEAR:        lin_mode = val[0];
      default: ;
    endcase
  endtask

  // offer one pointer beat and log its expectation once it is taken;
  // enters and leaves at a falling edge, valid stays up for the next beat
  task automatic offer_beat(logic [CW-1:0] x, logic [CW-1:0] y, logic v,
                            bit typed, stick_t want);
    while (!calm && $urandom_range(0, 99) < 28) begin
      in_valid = 1'b0;
      in_pointer_x = CW'($urandom);
      in_pointer_y = CW'($urandom);
      in_pointer_valid = 1'($urandom_range(0, 1));
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_pointer_x = x;
    in_pointer_y = y;
    in_pointer_valid = v;
    do @(posedge clk); while (!in_ready);
    pending_sticks.push_back(typed ? want : predict_sticks(x, y, v));
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid = 1'b0;
    wait (pending_sticks.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // result side: random stalls, plus one long hold-off on request
  int hold_left = 0;
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready = 1'b0;
    end else begin
      out_ready = calm || ($urandom_range(0, 99) >= 28);
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin
    stick_t exp_s;
    if (rst_n && out_valid && out_ready) begin
      if (pending_sticks.size() == 0) begin
        $error("result beat with nothing expected");
        fail_cnt++;
      end else begin
        exp_s = pending_sticks.pop_front();
        if (out_updated !== exp_s.updated) begin
          $error("updated: expected %0d got %0d", exp_s.updated, out_updated);
          fail_cnt++;
        end
        if (out_aileron !== exp_s.aileron) begin
          $error("aileron: expected %0d got %0d", exp_s.aileron, out_aileron);
          fail_cnt++;
        end
        if (out_elevator !== exp_s.elevator) begin
          $error("elevator: expected %0d got %0d", exp_s.elevator, out_elevator);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  // near-centre coordinate so the dead zone edge gets hit often
  function automatic logic [CW-1:0] near_coord(logic [CW-1:0] c, logic [CW-1:0] lim);
    int v;
    v = int'(c) + $urandom_range(0, 2 * dz_rad + 8) - int'(dz_rad) - 4;
    if (lim == 0) return CW'($urandom);
    if (v < 0) v = 0;
    if (v >= lim) v = lim - 1;
    return CW'(v);
  endfunction

  initial begin
    sample_row_t rows[$];
    stick_t zero_s, still_s;
    logic [CW-1:0] x, y;
    logic v;
    int pick;

    win_w = CW'(ptsds_pkg::RST_WINDOW_WIDTH);
    win_h = CW'(ptsds_pkg::RST_WINDOW_HEIGHT);
    cen_x = CW'(ptsds_pkg::RST_CENTER_X);
    cen_y = CW'(ptsds_pkg::RST_CENTER_Y);
    dz_rad = CW'(ptsds_pkg::RST_DEAD_ZONE);
    lin_mode = 1'b0;
    zero_s = '0;
    still_s = '{updated: 1'b1, aileron: '0, elevator: '0};

    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // spare indexes must leave the reset values alone
    write_reg(CFG_SPARE_LO, 12'hfff);
    write_reg(CFG_SPARE_HI, 12'h001);

    // directed beats against the reset settings
    rows = '{
      '{12'd512, 12'd384, 1'b1, 1, still_s},   // dead centre
      '{12'd512, 12'd384, 1'b0, 1, zero_s},    // failed query
      '{12'd1024, 12'd384, 1'b1, 1, zero_s},   // right of window
      '{12'd512, 12'd768, 1'b1, 1, zero_s},    // below window
      '{12'd4095, 12'd4095, 1'b1, 1, zero_s},
      '{12'd4095, 12'd4095, 1'b0, 1, zero_s},
      '{12'd532, 12'd384, 1'b1, 1, still_s},   // on the dead zone edge
      '{12'd512, 12'd364, 1'b1, 1, still_s},
      '{12'd524, 12'd400, 1'b1, 1, still_s},   // 12,16: d = 20
      '{12'd533, 12'd384, 1'b1, 0, zero_s},    // just outside
      '{12'd512, 12'd0, 1'b1, 0, zero_s},      // x offset zero
      '{12'd0, 12'd384, 1'b1, 0, zero_s},      // y offset zero
      '{12'd0, 12'd0, 1'b1, 0, zero_s},
      '{12'd1023, 12'd767, 1'b1, 0, zero_s},
      '{12'd1023, 12'd0, 1'b1, 0, zero_s},
      '{12'd0, 12'd767, 1'b1, 0, zero_s},
      '{12'd300, 12'd500, 1'b1, 0, zero_s},
      '{12'd2730, 12'd1365, 1'b0, 1, zero_s}   // alternating bits, invalid
    };
    calm = 1;
    foreach (rows[i]) offer_beat(rows[i].x, rows[i].y, rows[i].v, rows[i].typed, rows[i].want);
    calm = 0;
    settle();

    // random phases, each with its own register setting
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: begin  // widest window, centre at one, no dead zone, linear
          write_reg(ptsds_pkg::CFG_WINDOW_WIDTH, 12'd4095);
          write_reg(ptsds_pkg::CFG_WINDOW_HEIGHT, 12'd4095);
          write_reg(ptsds_pkg::CFG_CENTER_X, 12'd1);
          write_reg(ptsds_pkg::CFG_CENTER_Y, 12'd1);
          write_reg(ptsds_pkg::CFG_DEAD_ZONE, 12'd0);
          write_reg(ptsds_pkg::CFG_LINEAR, 12'd1);
        end
        1: begin  // largest centre and dead zone, squared
          write_reg(ptsds_pkg::CFG_CENTER_X, 12'd4095);
          write_reg(ptsds_pkg::CFG_CENTER_Y, 12'd4095);
          write_reg(ptsds_pkg::CFG_DEAD_ZONE, 12'd4095);
          write_reg(ptsds_pkg::CFG_LINEAR, 12'd0);
        end
        2: begin  // zero centre saturates
          write_reg(ptsds_pkg::CFG_CENTER_X, 12'd0);
          write_reg(ptsds_pkg::CFG_CENTER_Y, 12'd0);
          write_reg(ptsds_pkg::CFG_DEAD_ZONE, 12'd3);
        end
        3: begin  // zero window, nothing is inside
          write_reg(ptsds_pkg::CFG_WINDOW_WIDTH, 12'd0);
          write_reg(ptsds_pkg::CFG_WINDOW_HEIGHT, 12'd0);
        end
        4: begin  // one-pixel window
          write_reg(ptsds_pkg::CFG_WINDOW_WIDTH, 12'd1);
          write_reg(ptsds_pkg::CFG_WINDOW_HEIGHT, 12'd1);
          write_reg(ptsds_pkg::CFG_CENTER_X, 12'd1);
          write_reg(ptsds_pkg::CFG_CENTER_Y, 12'd1);
          write_reg(ptsds_pkg::CFG_DEAD_ZONE, 12'd0);
        end
        default: begin
          write_reg(ptsds_pkg::CFG_WINDOW_WIDTH, CW'($urandom_range(1, 4095)));
          write_reg(ptsds_pkg::CFG_WINDOW_HEIGHT, CW'($urandom_range(1, 4095)));
          write_reg(ptsds_pkg::CFG_CENTER_X, CW'($urandom_range(0, 4095)));
          write_reg(ptsds_pkg::CFG_CENTER_Y, CW'($urandom_range(0, 4095)));
          write_reg(ptsds_pkg::CFG_DEAD_ZONE, CW'($urandom_range(0, 300)));
          write_reg(ptsds_pkg::CFG_LINEAR, CW'($urandom_range(0, 1)));
        end
      endcase
      calm = (ph == 6);
      for (int n = 0; n < 150; n++) begin
        if (ph == 8 && n == 20) hold_req = 1;  // fill the block and stall its input
        pick = $urandom_range(0, 99);
        v = (pick >= 8);
        if (pick < 55) begin
          x = (win_w != 0) ? CW'($urandom_range(0, win_w - 1)) : CW'($urandom);
          y = (win_h != 0) ? CW'($urandom_range(0, win_h - 1)) : CW'($urandom);
        end else if (pick < 85) begin
          x = near_coord(cen_x, win_w);
          y = near_coord(cen_y, win_h);
        end else begin
          x = CW'($urandom);
          y = CW'($urandom);
        end
        offer_beat(x, y, v, 0, zero_s);
      end
      calm = 0;
      settle();
    end

    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
